>>> rtl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants for the level sensor median/EMA monitor.
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int DIST_W  = 13;
  localparam int SMOOTH_W = 21;
  localparam int FILL_W  = 10;
  localparam int CNT_W   = 8;
  localparam int HGT_W   = 10;
  localparam int NUM_W   = 20;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 8'd250;
  localparam logic [FILL_W-1:0] FILL_MAX  = 10'd1000;
  localparam logic [DIST_W-1:0] DIST_MAX  = 13'd8191;

  typedef enum logic [1:0] {
    CMD_READING   = 2'd0,
    CMD_CLR_ABOVE = 2'd1,
    CMD_CLR_BOTH  = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    HEALTH_STARTING = 2'd0,
    HEALTH_OK       = 2'd1,
    HEALTH_FAULT    = 2'd2,
    HEALTH_NOSENSOR = 2'd3
  } health_t;

  typedef enum logic [2:0] {
    REG_HEIGHT = 3'd0,
    REG_START  = 3'd1,
    REG_STOP   = 3'd2,
    REG_ALPHA  = 3'd3,
    REG_LIMIT  = 3'd4,
    REG_WINDOW = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_CHK,
    ST_EMA1,
    ST_EMA2,
    ST_RND,
    ST_DIVS,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

>>> rtl/lsm_div.sv
// ----------------------------------------------------------------------------
// lsm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsm_div
  import lsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [HGT_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [HGT_W-1:0]  rem;
  logic [HGT_W:0]    rem_sh;
  logic [HGT_W-1:0]  den_r;
  logic [STEP_W-1:0] steps;
  logic              busy;

  assign rem_sh = {rem, quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        // shift in next numerator bit, subtract when it fits
        if (rem_sh >= {1'b0, den_r}) begin
          rem <= HGT_W'(rem_sh - {1'b0, den_r});
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[HGT_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/level_sensor_median_ema_monitor.sv
// ----------------------------------------------------------------------------
// level_sensor_median_ema_monitor
// Median window, EMA smoothing, depth/fill and health tracking for a level sensor.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Command beats and failed readings go straight from
// the accept state to the output state. A valid reading runs a rank search over
// the filled window with one shared comparator (n candidates, each loaded and
// compared against every entry, stopping at the median), the EMA states, a
// rounding state and a 20-step bit-serial fill division, then waits in the output
// state while an earlier output is still held by m_axis_tready low.
// The input is not ready until the result is loaded in the output register.
module level_sensor_median_ema_monitor
  import lsm_pkg::*;
#(
  parameter int WINDOW_SIZE = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // distance_tenth_cm, elapsed_ms, zero pad
  input  logic [2:0]  s_axis_tuser,  // command, reading_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // health, sensor_good, smoothed_distance, water_depth, fill_tenth_percent,
  // below_start_count, above_stop_count, zero pad
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);

  // configuration
  logic [HGT_W-1:0] tank_height_cm;
  logic [6:0]       start_percent;
  logic [6:0]       stop_percent;
  logic [8:0]       smoothing_alpha;
  logic [7:0]       fail_limit;
  logic [31:0]      no_sensor_window_ms;
  reg_idx_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tank_height_cm      <= 10'd200;
      start_percent       <= 7'd20;
      stop_percent        <= 7'd90;
      smoothing_alpha     <= 9'd77;
      fail_limit          <= 8'd5;
      no_sensor_window_ms <= 32'd10000;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_HEIGHT: tank_height_cm      <= pwdata[9:0];
        REG_START:  start_percent       <= pwdata[6:0];
        REG_STOP:   stop_percent        <= pwdata[6:0];
        REG_ALPHA:  smoothing_alpha     <= pwdata[8:0];
        REG_LIMIT:  fail_limit          <= pwdata[7:0];
        REG_WINDOW: no_sensor_window_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HEIGHT: prdata = {22'd0, tank_height_cm};
      REG_START:  prdata = {25'd0, start_percent};
      REG_STOP:   prdata = {25'd0, stop_percent};
      REG_ALPHA:  prdata = {23'd0, smoothing_alpha};
      REG_LIMIT:  prdata = {24'd0, fail_limit};
      REG_WINDOW: prdata = no_sensor_window_ms;
      default:    prdata = '0;
    endcase
  end

  // input fields
  cmd_t              in_cmd;
  logic              in_valid;
  logic [DIST_W-1:0] in_dist;
  logic [31:0]       in_elapsed;

  assign in_cmd     = cmd_t'(s_axis_tuser[1:0]);
  assign in_valid   = s_axis_tuser[2];
  assign in_dist    = s_axis_tdata[12:0];
  assign in_elapsed = s_axis_tdata[44:13];

  // state
  state_t               state, state_next;
  logic [DIST_W-1:0]    win [WINDOW_SIZE];
  logic [CW-1:0]        win_fill;
  logic [IW-1:0]        win_head;
  logic [SMOOTH_W-1:0]  smooth_q8;
  logic                 smooth_present;
  logic [CNT_W-1:0]     fail_count;
  logic                 ever_seen;
  health_t              health;
  logic [CNT_W-1:0]     below_count;
  logic [CNT_W-1:0]     above_count;
  logic [DIST_W-1:0]    last_distance;
  logic [DIST_W-1:0]    last_depth;
  logic [FILL_W-1:0]    last_fill;

  // rank search
  logic [IW-1:0]     cand_idx;
  logic [IW-1:0]     cmp_idx;
  logic [IW-1:0]     rd_idx;
  logic [DIST_W-1:0] rd_data;
  logic [DIST_W-1:0] cand;
  logic [CW-1:0]     lt_cnt;
  logic [CW-1:0]     eq_cnt;
  logic [CW-1:0]     mid_rank;
  logic [CW:0]       le_sum;
  logic [DIST_W-1:0] median;

  // arithmetic
  logic [8:0]          alpha_eff;
  logic [29:0]         prod;
  logic [SMOOTH_W:0]   ema_sum;
  logic [SMOOTH_W:0]   rnd_sum;
  logic [DIST_W:0]     dist_r;
  logic [DIST_W-1:0]   dist_c;
  logic [DIST_W:0]     hgt10;
  logic [DIST_W:0]     depth_w;
  logic [DIST_W-1:0]   depth_c;
  logic [NUM_W-1:0]    quo;
  logic                div_done;
  logic                div_start;
  logic [FILL_W-1:0]   fill_c;
  logic [CNT_W-1:0]    fail_inc;
  logic                recover;
  logic [IW-1:0]       head_eff;
  logic [CW-1:0]       fill_eff;
  logic                accept;
  logic                out_load;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign recover  = (health != HEALTH_OK);
  assign head_eff = recover ? '0 : win_head;
  assign fill_eff = recover ? '0 : win_fill;
  assign fail_inc = (fail_count < COUNT_MAX) ? fail_count + 1'b1 : fail_count;

  assign rd_idx   = (state == ST_LOAD) ? cand_idx : cmp_idx;
  assign rd_data  = win[rd_idx];
  assign mid_rank = win_fill >> 1;
  assign le_sum   = {1'b0, lt_cnt} + {1'b0, eq_cnt};

  assign alpha_eff = (smoothing_alpha > 9'd256) ? 9'd256 : smoothing_alpha;
  assign ema_sum   = (SMOOTH_W+1)'(prod[29:8]) + (SMOOTH_W+1)'(median * alpha_eff);
  assign rnd_sum   = {1'b0, smooth_q8} + (SMOOTH_W+1)'(128);
  assign dist_r    = rnd_sum[SMOOTH_W:8];
  assign dist_c    = (dist_r > {1'b0, DIST_MAX}) ? DIST_MAX : dist_r[DIST_W-1:0];
  assign hgt10     = (DIST_W+1)'(tank_height_cm * 4'd10);
  assign depth_w   = (hgt10 > {1'b0, dist_c}) ? hgt10 - {1'b0, dist_c} : '0;
  assign depth_c   = (depth_w > {1'b0, DIST_MAX}) ? DIST_MAX : depth_w[DIST_W-1:0];
  assign fill_c    = (tank_height_cm == '0) ? '0 :
                     (quo > NUM_W'(FILL_MAX)) ? FILL_MAX : quo[FILL_W-1:0];

  lsm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NUM_W'(last_depth * 7'd100)),
    .den   (tank_height_cm),
    .quo   (quo),
    .done  (div_done)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_READING && in_valid) state_next = ST_LOAD;
          else state_next = ST_OUT;
        end
      end
      ST_LOAD: state_next = ST_CMP;
      ST_CMP:  if (cmp_idx == IW'(win_fill - 1'b1)) state_next = ST_CHK;
      ST_CHK: begin
        if ({1'b0, lt_cnt} <= {1'b0, mid_rank} && {1'b0, mid_rank} < le_sum)
          state_next = ST_EMA1;
        else
          state_next = ST_LOAD;
      end
      ST_EMA1: state_next = smooth_present ? ST_EMA2 : ST_RND;
      ST_EMA2: state_next = ST_RND;
      ST_RND:  state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_FIN;
      ST_FIN:  state_next = ST_OUT;
      ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !rst;
    div_start     = (state == ST_DIVS);
    out_load      = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      win_fill       <= '0;
      win_head       <= '0;
      smooth_q8      <= '0;
      smooth_present <= 1'b0;
      fail_count     <= '0;
      ever_seen      <= 1'b0;
      health         <= HEALTH_STARTING;
      below_count    <= '0;
      above_count    <= '0;
      last_distance  <= '0;
      last_depth     <= '0;
      last_fill      <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      m_axis_tvalid <= out_load || (m_axis_tvalid && !m_axis_tready);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority case (in_cmd)
              CMD_READING: begin
                if (in_valid) begin
                  if (recover) begin
                    smooth_present <= 1'b0;
                    smooth_q8      <= '0;
                    below_count    <= '0;
                    above_count    <= '0;
                  end
                  ever_seen      <= 1'b1;
                  fail_count     <= '0;
                  win[head_eff]  <= in_dist;
                  win_head <= (head_eff == IW'(WINDOW_SIZE - 1)) ? '0 : head_eff + 1'b1;
                  win_fill <= (fill_eff < CW'(WINDOW_SIZE)) ? fill_eff + 1'b1 : fill_eff;
                  cand_idx <= '0;
                end else begin
                  fail_count <= fail_inc;
                  if (!ever_seen) begin
                    if (in_elapsed > no_sensor_window_ms) health <= HEALTH_NOSENSOR;
                  end else if (fail_inc >= fail_limit) begin
                    health <= HEALTH_FAULT;
                  end
                end
              end
              CMD_CLR_ABOVE: above_count <= '0;
              CMD_CLR_BOTH: begin
                below_count <= '0;
                above_count <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          cand    <= rd_data;
          cmp_idx <= '0;
          lt_cnt  <= '0;
          eq_cnt  <= '0;
        end
        ST_CMP: begin
          if (rd_data < cand) lt_cnt <= lt_cnt + 1'b1;
          if (rd_data == cand) eq_cnt <= eq_cnt + 1'b1;
          cmp_idx <= cmp_idx + 1'b1;
        end
        ST_CHK: begin
          median   <= cand;
          cand_idx <= cand_idx + 1'b1;
        end
        ST_EMA1: begin
          if (!smooth_present) begin
            smooth_q8      <= {median, 8'd0};
            smooth_present <= 1'b1;
          end else begin
            prod <= 30'(smooth_q8) * 30'(9'd256 - alpha_eff);
          end
        end
        ST_EMA2: smooth_q8 <= ema_sum[SMOOTH_W-1:0];
        ST_RND: begin
          last_distance <= dist_c;
          last_depth    <= depth_c;
        end
        ST_FIN: begin
          last_fill <= fill_c;
          health    <= HEALTH_OK;
          // both thresholds compare against the freshly computed fill
          if ({1'b0, fill_c} < start_percent * 4'd10) begin
            if (below_count < COUNT_MAX) below_count <= below_count + 1'b1;
          end else begin
            below_count <= '0;
          end
          if ({1'b0, fill_c} >= stop_percent * 4'd10) begin
            if (above_count < COUNT_MAX) above_count <= above_count + 1'b1;
          end else begin
            above_count <= '0;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            m_axis_tdata  <= {1'b0, above_count, below_count, last_fill, last_depth,
                              last_distance, (health == HEALTH_OK), health};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
